### hdl/utf8v_pkg.sv
// Package for the UTF-8 stream validator.
// Holds the fault codes and the per-byte step struct; no dependencies.
package utf8v_pkg;

   localparam int FaultWidth = 3;

   // Fault codes, as reported on rsp_fault_kind
   localparam logic [FaultWidth-1:0] FAULT_NONE      = 3'd0;
   localparam logic [FaultWidth-1:0] FAULT_BAD_LEAD  = 3'd1;
   localparam logic [FaultWidth-1:0] FAULT_OVERLONG  = 3'd2;
   localparam logic [FaultWidth-1:0] FAULT_ABOVE_F4  = 3'd3;
   localparam logic [FaultWidth-1:0] FAULT_BAD_CONT  = 3'd4;
   localparam logic [FaultWidth-1:0] FAULT_TRUNCATED = 3'd5;
   localparam logic [FaultWidth-1:0] FAULT_ZERO      = 3'd6;

   // Sequence state carried from byte to byte
   typedef struct packed {
      logic [1:0]            pending;
      logic [FaultWidth-1:0] fault;
   } seq_state_type;

endpackage

### hdl/utf8v_decode.sv
// Per-byte decision logic of the UTF-8 stream validator.
// Uses utf8v_pkg for fault codes and the sequence state struct.
module utf8v_decode
   import utf8v_pkg::*;
(
   input  logic [7:0]    data_byte,
   input  logic          end_of_string,
   input  seq_state_type cur_state,
   output seq_state_type next_state
);

   logic [1:0]            pend_step;
   logic [FaultWidth-1:0] code_step;
   logic [FaultWidth-1:0] fault_step;

   // Classify the byte against the continuations still expected
   always_comb begin
      pend_step = cur_state.pending;
      code_step = FAULT_NONE;
      if (cur_state.pending != 2'd0) begin
         if (data_byte[7:6] != 2'b10) begin
            code_step = FAULT_BAD_CONT;
            pend_step = 2'd0;
         end else begin
            pend_step = cur_state.pending - 2'd1;
         end
      end else if (data_byte[7] == 1'b0) begin
         if (data_byte == 8'h00) begin
            code_step = FAULT_ZERO;
         end
      end else if (data_byte[7:5] == 3'b110) begin
         if (data_byte[4:1] == 4'd0) begin
            code_step = FAULT_OVERLONG;
         end else begin
            pend_step = 2'd1;
         end
      end else if (data_byte[7:4] == 4'b1110) begin
         pend_step = 2'd2;
      end else if (data_byte[7:3] == 5'b11110) begin
         if (data_byte > 8'hF4) begin
            code_step = FAULT_ABOVE_F4;
         end else begin
            pend_step = 2'd3;
         end
      end else begin
         code_step = FAULT_BAD_LEAD;
      end
   end

   // Keep the first fault; flag truncation on the final byte
   always_comb begin
      fault_step = cur_state.fault;
      if (fault_step == FAULT_NONE) begin
         fault_step = code_step;
      end
      if (end_of_string && (pend_step != 2'd0) && (fault_step == FAULT_NONE)) begin
         fault_step = FAULT_TRUNCATED;
      end
      next_state.pending = pend_step;
      next_state.fault   = fault_step;
   end

endmodule

### hdl/utf8_stream_validator_top.sv
// UTF-8 stream validator: one byte per item, one verdict per string.
// A final byte goes from the input register through decode into the result
// register. Throughput: one byte per cycle, except that a final byte waits
// while the result slot is full; the two-bit pending counter steps per byte.
// Reset (synchronous, active high) empties both registers and clears the
// sequence state to no pending continuations and no fault.
module utf8_stream_validator_top
   import utf8v_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_end_of_string,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_string_valid,
   output logic [FaultWidth-1:0] rsp_fault_kind
);

   logic                  s1_valid_ff;
   logic [7:0]            s1_byte_ff;
   logic                  s1_eos_ff;
   seq_state_type         state_ff;
   seq_state_type         state_step;
   logic                  out_valid_ff;
   logic                  out_string_valid_ff;
   logic [FaultWidth-1:0] out_fault_ff;
   logic                  out_free;
   logic                  s1_fire;

   // Advance a byte unless it carries a verdict and the result slot is full
   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_eos_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;

   utf8v_decode u_decode (
      .data_byte     (s1_byte_ff),
      .end_of_string (s1_eos_ff),
      .cur_state     (state_ff),
      .next_state    (state_step)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         s1_byte_ff <= req_data_byte;
         s1_eos_ff  <= req_end_of_string;
      end
   end

   // Sequence state: update per byte, clear after each verdict
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.pending <= 2'd0;
         state_ff.fault   <= FAULT_NONE;
      end else if (s1_fire) begin
         if (s1_eos_ff) begin
            state_ff.pending <= 2'd0;
            state_ff.fault   <= FAULT_NONE;
         end else begin
            state_ff <= state_step;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_fire && s1_eos_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (s1_fire && s1_eos_ff) begin
         out_string_valid_ff <= (state_step.fault == FAULT_NONE);
         out_fault_ff        <= state_step.fault;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_string_valid = out_string_valid_ff;
   assign rsp_fault_kind   = out_fault_ff;

   // Verdict and fault code agree
   a_verdict_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_string_valid == (rsp_fault_kind == FAULT_NONE)))
      else $error("verdict disagrees with fault code");

   // State returns to reset values after a verdict
   a_state_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_eos_ff) |=> (state_ff.pending == 2'd0 && state_ff.fault == FAULT_NONE))
      else $error("sequence state not cleared after verdict");

   // First fault is kept until the end of the string
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !s1_eos_ff && state_ff.fault != FAULT_NONE)
      |=> (state_ff.fault == $past(state_ff.fault)))
      else $error("first fault overwritten");

   // A verdict never overwrites one still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !(s1_fire && s1_eos_ff))
      else $error("result register overrun");

endmodule
